// ----- rtl/core/lpst_pkg.sv -----
// Shared types, codes and lookup functions for the LED pattern sequencer.
package lpst_pkg;

   // Item kinds
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SENSOR = 1'b1;

   // Pattern codes
   localparam logic [2:0] PAT_OFF   = 3'd0;
   localparam logic [2:0] PAT_SLOW  = 3'd1;
   localparam logic [2:0] PAT_FAST  = 3'd2;
   localparam logic [2:0] PAT_HEART = 3'd3;
   localparam logic [2:0] PAT_SOS   = 3'd4;
   localparam logic [2:0] PAT_COUNT = 3'd5;

   // Alarm codes
   localparam logic [1:0] ALARM_NONE = 2'd0;
   localparam logic [1:0] ALARM_HIGH = 2'd1;
   localparam logic [1:0] ALARM_LOW  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_WINDOW_COUNT  = 3'd0;
   localparam logic [2:0] CSR_HIGH_LIMIT    = 3'd1;
   localparam logic [2:0] CSR_LOW_LIMIT     = 3'd2;
   localparam logic [2:0] CSR_VALID_UPPER   = 3'd3;
   localparam logic [2:0] CSR_FAST_ABOVE    = 3'd4;
   localparam logic [2:0] CSR_MID_ABOVE     = 3'd5;
   localparam logic [2:0] CSR_ADVANCE_TICKS = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   // Timing constants in milliseconds
   localparam logic [9:0]  HOLD_DOT           = 10'd200;
   localparam logic [9:0]  HOLD_DASH          = 10'd600;
   localparam logic [10:0] PERIOD_SAMPLE_FAST = 11'd500;
   localparam logic [10:0] PERIOD_SAMPLE_MID  = 11'd1000;
   localparam logic [10:0] PERIOD_SAMPLE_SLOW = 11'd2000;

   localparam logic [3:0] SOS_LAST  = 4'd8;
   localparam logic [3:0] SOS_LEN   = 4'd9;
   localparam logic [5:0] STEP_LAST = 6'd39;

   typedef struct packed {
      logic              mode;
      logic signed [15:0] temperature;
   } req_type;

   typedef struct packed {
      logic        led_update;
      logic [2:0]  led_bits;
      logic [9:0]  hold_ms;
      logic [10:0] next_period_ms;
      logic [2:0]  pattern;
      logic        pattern_changed;
      logic        sample_valid;
      logic [1:0]  temp_alarm;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  window_count;
      logic [14:0] high_average_limit;
      logic [14:0] low_average_limit;
      logic [14:0] valid_upper;
      logic [14:0] fast_sample_above;
      logic [14:0] mid_sample_above;
      logic [5:0]  advance_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] active_pattern;
      logic [5:0] pattern_step_count;
      logic       blink_level;
      logic [3:0] sos_position;
      logic [5:0] tick_count;
   } pat_state_type;

   function automatic logic [10:0] tick_period(input logic [2:0] pat);
      logic [10:0] period;
      case (pat)
         PAT_OFF:   period = 11'd1000;
         PAT_SLOW:  period = 11'd1000;
         PAT_FAST:  period = 11'd200;
         PAT_HEART: period = 11'd100;
         PAT_SOS:   period = 11'd200;
         PAT_COUNT: period = 11'd300;
         default:   period = 11'd1000;
      endcase
      return period;
   endfunction

   // Successor modulo six over the six defined codes; code 6 maps to slow and code 7 to fast
   function automatic logic [2:0] next_pattern(input logic [2:0] pat);
      logic [2:0] nxt;
      case (pat)
         PAT_OFF:   nxt = PAT_SLOW;
         PAT_SLOW:  nxt = PAT_FAST;
         PAT_FAST:  nxt = PAT_HEART;
         PAT_HEART: nxt = PAT_SOS;
         PAT_SOS:   nxt = PAT_COUNT;
         PAT_COUNT: nxt = PAT_OFF;
         3'd6:      nxt = PAT_SLOW;
         default:   nxt = PAT_FAST;
      endcase
      return nxt;
   endfunction

   // Step is kept below 40: reduce by tens with a compare chain
   function automatic logic [3:0] step_mod10(input logic [5:0] step);
      logic [5:0] r;
      if (step >= 6'd30) r = step - 6'd30;
      else if (step >= 6'd20) r = step - 6'd20;
      else if (step >= 6'd10) r = step - 6'd10;
      else r = step;
      return r[3:0];
   endfunction

   // Dot dot dot dash dash dash dot dot dot
   function automatic logic sos_is_dash(input logic [3:0] pos);
      return (pos >= 4'd3) && (pos <= 4'd5);
   endfunction

endpackage

// ----- rtl/core/lpst_step.sv -----
// Per-item update: LED pattern tick and sensor window averaging.
module lpst_step #(
   parameter int MAX_WINDOW = 16,
   localparam int WIN_CAP = (MAX_WINDOW < 31) ? MAX_WINDOW : 31,
   localparam int CNT_W   = $clog2(WIN_CAP + 1),
   localparam int SUM_W   = $clog2(WIN_CAP * 32767 + 1)
) (
   input  lpst_pkg::req_type       item,
   input  lpst_pkg::cfg_type       cfg,
   input  lpst_pkg::pat_state_type pat,
   input  logic [SUM_W-1:0]        sum,
   input  logic [CNT_W-1:0]        count,
   output lpst_pkg::rsp_type       rsp,
   output lpst_pkg::pat_state_type pat_next,
   output logic [SUM_W-1:0]        sum_next,
   output logic [CNT_W-1:0]        count_next
);

   localparam int PROD_W  = 15 + CNT_W;
   localparam logic [4:0] WIN_CAP_V = 5'(WIN_CAP);

   logic [3:0]        step_mod;
   logic [3:0]        sos_pos;
   logic [5:0]        tick_inc;
   logic [5:0]        adv;
   logic [4:0]        win;
   logic              reading_ok;
   logic [SUM_W-1:0]  sum_inc;
   logic [CNT_W-1:0]  count_inc;
   logic [PROD_W-1:0] high_prod;
   logic [PROD_W-1:0] low_prod;
   logic [PROD_W-1:0] sum_ext;

   // Window averaging datapath
   assign reading_ok = !item.temperature[15] && (item.temperature[14:0] <= cfg.valid_upper);
   assign sum_inc    = sum + SUM_W'(item.temperature[14:0]);
   assign count_inc  = count + CNT_W'(1);
   assign sum_ext    = PROD_W'(sum_inc);
   assign high_prod  = PROD_W'(cfg.high_average_limit) * PROD_W'(count_inc);
   assign low_prod   = PROD_W'(cfg.low_average_limit) * PROD_W'(count_inc);

   always_comb begin
      if (cfg.window_count == 5'd0) begin
         win = 5'd1;
      end else if (cfg.window_count > WIN_CAP_V) begin
         win = WIN_CAP_V;
      end else begin
         win = cfg.window_count;
      end
   end

   assign adv      = (cfg.advance_ticks == 6'd0) ? 6'd1 : cfg.advance_ticks;
   assign tick_inc = pat.tick_count + 6'd1;
   assign step_mod = lpst_pkg::step_mod10(pat.pattern_step_count);
   assign sos_pos  = (pat.sos_position >= lpst_pkg::SOS_LEN) ?
                     (pat.sos_position - lpst_pkg::SOS_LEN) : pat.sos_position;

   always_comb begin
      rsp        = '0;
      pat_next   = pat;
      sum_next   = sum;
      count_next = count;
      if (item.mode == lpst_pkg::MODE_TICK) begin
         rsp.led_update     = 1'b1;
         rsp.next_period_ms = lpst_pkg::tick_period(pat.active_pattern);
         case (pat.active_pattern)
            lpst_pkg::PAT_SLOW: begin
               pat_next.blink_level = ~pat.blink_level;
               rsp.led_bits         = {2'b00, ~pat.blink_level};
            end
            lpst_pkg::PAT_FAST: begin
               pat_next.blink_level = ~pat.blink_level;
               rsp.led_bits         = {1'b0, ~pat.blink_level, 1'b0};
            end
            lpst_pkg::PAT_HEART: begin
               rsp.led_bits = ((step_mod < 4'd2) || ((step_mod >= 4'd3) && (step_mod < 4'd5))) ?
                              3'b100 : 3'b000;
               pat_next.pattern_step_count = (pat.pattern_step_count == lpst_pkg::STEP_LAST) ?
                                             6'd0 : pat.pattern_step_count + 6'd1;
            end
            lpst_pkg::PAT_SOS: begin
               rsp.led_bits = 3'b111;
               rsp.hold_ms  = lpst_pkg::sos_is_dash(sos_pos) ?
                              lpst_pkg::HOLD_DASH : lpst_pkg::HOLD_DOT;
               pat_next.sos_position = (sos_pos == lpst_pkg::SOS_LAST) ? 4'd0 : sos_pos + 4'd1;
            end
            lpst_pkg::PAT_COUNT: begin
               rsp.led_bits = pat.pattern_step_count[2:0];
               pat_next.pattern_step_count = (pat.pattern_step_count == lpst_pkg::STEP_LAST) ?
                                             6'd0 : pat.pattern_step_count + 6'd1;
            end
            default: begin
               rsp.led_bits = 3'b000;
            end
         endcase
         // Advance the pattern after this tick has driven the LEDs
         if (tick_inc >= adv) begin
            pat_next.tick_count         = 6'd0;
            pat_next.active_pattern     = lpst_pkg::next_pattern(pat.active_pattern);
            pat_next.pattern_step_count = 6'd0;
            pat_next.blink_level        = 1'b0;
            rsp.pattern_changed         = 1'b1;
         end else begin
            pat_next.tick_count = tick_inc;
         end
      end else begin
         if (item.temperature > $signed({1'b0, cfg.fast_sample_above})) begin
            rsp.next_period_ms = lpst_pkg::PERIOD_SAMPLE_FAST;
         end else if (item.temperature > $signed({1'b0, cfg.mid_sample_above})) begin
            rsp.next_period_ms = lpst_pkg::PERIOD_SAMPLE_MID;
         end else begin
            rsp.next_period_ms = lpst_pkg::PERIOD_SAMPLE_SLOW;
         end
         rsp.sample_valid = reading_ok;
         if (reading_ok) begin
            if (5'(count_inc) >= win) begin
               if (sum_ext > high_prod) begin
                  pat_next.active_pattern     = lpst_pkg::PAT_FAST;
                  pat_next.pattern_step_count = 6'd0;
                  pat_next.blink_level        = 1'b0;
                  rsp.pattern_changed         = 1'b1;
                  rsp.temp_alarm              = lpst_pkg::ALARM_HIGH;
               end else if (sum_ext < low_prod) begin
                  pat_next.active_pattern     = lpst_pkg::PAT_SOS;
                  pat_next.pattern_step_count = 6'd0;
                  pat_next.blink_level        = 1'b0;
                  rsp.pattern_changed         = 1'b1;
                  rsp.temp_alarm              = lpst_pkg::ALARM_LOW;
               end
               sum_next   = '0;
               count_next = '0;
            end else begin
               sum_next   = sum_inc;
               count_next = count_inc;
            end
         end
      end
      rsp.pattern = pat_next.active_pattern;
   end

endmodule

// ----- rtl/core/led_pattern_sequencer_with_temp_average.sv -----
// An accepted item passes from the input register through the result register to the rsp port.
// Throughput: one item per cycle while the result is not stalled; the pattern and window state
// close their loop through the update logic between the input register and the result register.
// A stalled result holds in the output register while one more item waits in the input register.
// Reset (synchronous, active high) empties both registers, loads the register defaults,
// selects slow blink and clears all counters and the reading window.
module led_pattern_sequencer_with_temp_average #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lpst_pkg::req_type                req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lpst_pkg::rsp_type                rsp_item,
   input  logic                             csr_we,
   input  logic [lpst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpst_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WIN_CAP = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
   localparam int CNT_W   = $clog2(WIN_CAP + 1);
   localparam int SUM_W   = $clog2(WIN_CAP * 32767 + 1);

   lpst_pkg::cfg_type       cfg_ff;
   lpst_pkg::pat_state_type pat_ff;
   lpst_pkg::pat_state_type pat_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W-1:0]        sum_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    s1_valid_ff;
   lpst_pkg::req_type       s1_item_ff;
   logic                    rsp_valid_ff;
   lpst_pkg::rsp_type       rsp_item_ff;
   lpst_pkg::rsp_type       rsp_in;
   logic                    out_free;
   logic                    s1_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   lpst_step #(
      .MAX_WINDOW(MAX_WINDOW)
   ) u_step (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .pat        (pat_ff),
      .sum        (sum_ff),
      .count      (count_ff),
      .rsp        (rsp_in),
      .pat_next   (pat_in),
      .sum_next   (sum_in),
      .count_next (count_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_count       <= 5'd10;
         cfg_ff.high_average_limit <= 15'd3500;
         cfg_ff.low_average_limit  <= 15'd1500;
         cfg_ff.valid_upper        <= 15'd5000;
         cfg_ff.fast_sample_above  <= 15'd4000;
         cfg_ff.mid_sample_above   <= 15'd2500;
         cfg_ff.advance_ticks      <= 6'd50;
      end else if (csr_we) begin
         case (csr_index)
            lpst_pkg::CSR_WINDOW_COUNT:  cfg_ff.window_count       <= csr_wdata[4:0];
            lpst_pkg::CSR_HIGH_LIMIT:    cfg_ff.high_average_limit <= csr_wdata;
            lpst_pkg::CSR_LOW_LIMIT:     cfg_ff.low_average_limit  <= csr_wdata;
            lpst_pkg::CSR_VALID_UPPER:   cfg_ff.valid_upper        <= csr_wdata;
            lpst_pkg::CSR_FAST_ABOVE:    cfg_ff.fast_sample_above  <= csr_wdata;
            lpst_pkg::CSR_MID_ABOVE:     cfg_ff.mid_sample_above   <= csr_wdata;
            lpst_pkg::CSR_ADVANCE_TICKS: cfg_ff.advance_ticks      <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pat_ff.active_pattern     <= lpst_pkg::PAT_SLOW;
         pat_ff.pattern_step_count <= 6'd0;
         pat_ff.blink_level        <= 1'b0;
         pat_ff.sos_position       <= 4'd0;
         pat_ff.tick_count         <= 6'd0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         // Commit state as the item moves into the result register
         if (s1_fire) begin
            pat_ff   <= pat_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         rsp_item_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/lpst_checker.sv -----
// Port-level checks for the LED pattern sequencer, bound to the top level.
module lpst_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lpst_pkg::rsp_type rsp_item
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A tick never carries sensor status; a sensor item never drives LEDs
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_item.led_update && !rsp_item.sample_valid &&
          rsp_item.temp_alarm == lpst_pkg::ALARM_NONE) ||
         (!rsp_item.led_update && rsp_item.led_bits == 3'd0 && rsp_item.hold_ms == 10'd0))
      else $error("result fields mix item kinds");

   // An alarm always reselects a pattern, from a valid reading
   a_alarm_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.temp_alarm != lpst_pkg::ALARM_NONE |->
         rsp_item.pattern_changed && rsp_item.sample_valid &&
         ((rsp_item.temp_alarm == lpst_pkg::ALARM_HIGH && rsp_item.pattern == lpst_pkg::PAT_FAST) ||
          (rsp_item.temp_alarm == lpst_pkg::ALARM_LOW && rsp_item.pattern == lpst_pkg::PAT_SOS)))
      else $error("alarm without matching pattern change");

   // Pattern stays within the six defined codes
   a_pattern_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.pattern <= lpst_pkg::PAT_COUNT)
      else $error("pattern code out of range");

endmodule

bind led_pattern_sequencer_with_temp_average lpst_checker u_lpst_checker (.*);
